### design/sk3_pkg.sv
// shared constants and types for the three-axis scalar kalman block
`default_nettype none
package sk3_pkg;

  localparam int NUM_AXES  = 3;
  localparam int AX_IDX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int SAMPLE_W  = 16;
  localparam int AXIS_W    = 2;
  localparam int EST_W     = 24;
  localparam int ERR_W     = 24;
  localparam int ME_W      = 24;
  localparam int PN_W      = 16;
  localparam int GAIN_W    = 16;
  localparam int FRAC_W    = 8;
  localparam int CNT_W     = $clog2(GAIN_W);
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [ERR_W-1:0]  ERR_RESET = 24'd65536;
  localparam logic [ME_W-1:0]   ME_RESET  = 24'd65536;
  localparam logic [PN_W-1:0]   PN_RESET  = 16'd655;
  localparam logic [ERR_W-1:0]  ERR_MAX   = 24'hFFFFFF;
  localparam logic [GAIN_W:0]   ONE_Q16   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = 16'hFFFF;

  // register index, taken from paddr bit 2
  localparam logic REG_MEASURE_ERROR = 1'b0;
  localparam logic REG_PROCESS_NOISE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [AXIS_W-1:0]          axis;
    logic                       axis_ok;
  } sk3_req_t;

endpackage
`default_nettype wire

### design/sk3_front.sv
// front end: takes requests, flags the axis and holds them in a two-entry queue
`default_nettype none
module sk3_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [sk3_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [sk3_pkg::AXIS_W-1:0]         in_axis,
  output logic                                    q_valid,
  output sk3_pkg::sk3_req_t                       q_req,
  input  wire logic                               q_pop
);
  import sk3_pkg::*;

  sk3_req_t   fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  sk3_req_t   new_req;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_req    = fifo_r[rd_ptr_r];

  always_comb begin
    new_req.sample  = in_sample;
    new_req.axis    = in_axis;
    new_req.axis_ok = ({2'b00, in_axis} < 4'(NUM_AXES));
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_req;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) && !pop |=> (count_r == 2'd2))
    else $error("full queue lost an entry without a pop");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) || (count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

### design/sk3_back.sv
// back end: per-axis state, gain divider, update arithmetic and result register
`default_nettype none
module sk3_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire sk3_pkg::sk3_req_t              q_req,
  output logic                                q_pop,
  input  wire logic [sk3_pkg::ME_W-1:0]       measure_error,
  input  wire logic [sk3_pkg::PN_W-1:0]       process_noise,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [sk3_pkg::EST_W-1:0]    out_estimate,
  output logic [sk3_pkg::AXIS_W-1:0]          out_axis
);
  import sk3_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_MUL3  = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // per-axis filter state
  logic signed [EST_W-1:0] est_r [NUM_AXES];
  logic [ERR_W-1:0]        err_r [NUM_AXES];

  // working registers for one request
  logic [AX_IDX_W-1:0]     idx_r;
  logic [AXIS_W-1:0]       axis_r;
  logic                    ok_r;
  logic signed [EST_W-1:0] last_r;
  logic [ERR_W-1:0]        cur_err_r;
  logic [ERR_W:0]          den_r;
  logic [ERR_W:0]          rem_r;
  logic [GAIN_W-1:0]       quot_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;
  logic [EST_W-1:0]        absdiff_r;
  logic [EST_W-1:0]        mag_r;
  logic [ERR_W-1:0]        keep_r;
  logic [PN_W+EST_W-FRAC_W:0] noise_r;

  logic                    out_valid_r;
  logic signed [EST_W-1:0] out_est_r;
  logic [AXIS_W-1:0]       out_axis_r;

  // load-time values
  logic [AX_IDX_W-1:0]     ld_idx;
  logic signed [EST_W-1:0] ld_last;
  logic [ERR_W-1:0]        ld_err;
  logic signed [EST_W:0]   ld_diff;
  logic signed [EST_W-1:0] ld_target;

  // divider step
  logic [ERR_W+1:0]        rem_dbl;
  logic                    q_bit;

  // products
  logic [GAIN_W+EST_W-1:0]     prod_mag;
  logic [GAIN_W+EST_W:0]       prod_keep;
  logic [PN_W+EST_W-1:0]       prod_noise;
  logic [GAIN_W:0]             one_minus_gain;

  // final update
  logic [PN_W+EST_W-FRAC_W+1:0] err_sum;
  logic [ERR_W-1:0]             err_new;
  logic signed [EST_W:0]        est_wide;
  logic signed [EST_W-1:0]      est_new;
  logic                         out_load;

  assign ld_idx    = AX_IDX_W'(q_req.axis);
  assign ld_last   = est_r[ld_idx];
  assign ld_err    = err_r[ld_idx];
  assign ld_target = {q_req.sample, {FRAC_W{1'b0}}};
  assign ld_diff   = {ld_target[EST_W-1], ld_target} - {ld_last[EST_W-1], ld_last};

  assign rem_dbl = {rem_r, 1'b0};
  assign q_bit   = (rem_dbl >= {1'b0, den_r});

  assign one_minus_gain = ONE_Q16 - {1'b0, quot_r};
  assign prod_mag       = quot_r * absdiff_r;
  assign prod_keep      = one_minus_gain * cur_err_r;
  assign prod_noise     = mag_r * process_noise;

  assign err_sum = {{(PN_W+EST_W-FRAC_W+2-ERR_W){1'b0}}, keep_r} + {1'b0, noise_r};
  assign err_new = (err_sum > {{(PN_W+EST_W-FRAC_W+2-ERR_W){1'b0}}, ERR_MAX}) ?
                   ERR_MAX : err_sum[ERR_W-1:0];
  assign est_wide = neg_r ? ({last_r[EST_W-1], last_r} - {1'b0, mag_r})
                          : ({last_r[EST_W-1], last_r} + {1'b0, mag_r});
  assign est_new  = est_wide[EST_W-1:0];

  assign out_load = (state_r == S_WRITE) && (!out_valid_r || !out_stall);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_axis     = out_axis_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (!q_req.axis_ok) begin
            state_nxt = S_WRITE;
          end else if (measure_error == '0) begin
            state_nxt = S_MUL1;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_MUL3;
      S_MUL3:  state_nxt = S_WRITE;
      S_WRITE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          idx_r     <= ld_idx;
          axis_r    <= q_req.axis;
          ok_r      <= q_req.axis_ok;
          last_r    <= ld_last;
          cur_err_r <= ld_err;
          den_r     <= {1'b0, ld_err} + {1'b0, measure_error};
          rem_r     <= {1'b0, ld_err};
          cnt_r     <= CNT_W'(GAIN_W - 1);
          neg_r     <= ld_diff[EST_W];
          absdiff_r <= ld_diff[EST_W] ? EST_W'(-ld_diff) : ld_diff[EST_W-1:0];
          // zero measurement error: gain saturates, or is zero with zero error
          quot_r    <= (ld_err != '0) ? GAIN_MAX : '0;
        end
      end
      S_DIV: begin
        // the remainder can reach the full divisor width
        rem_r  <= q_bit ? (ERR_W+1)'(rem_dbl - {1'b0, den_r})
                        : rem_dbl[ERR_W:0];
        quot_r <= {quot_r[GAIN_W-2:0], q_bit};
        cnt_r  <= cnt_r - 1'b1;
      end
      S_MUL1: begin
        mag_r <= EST_W'((prod_mag + (GAIN_W+EST_W)'(32768)) >> GAIN_W);
      end
      S_MUL2: begin
        keep_r <= ERR_W'(({1'b0, prod_keep} + (GAIN_W+EST_W+2)'(32768)) >> GAIN_W);
      end
      S_MUL3: begin
        noise_r <= (PN_W+EST_W-FRAC_W+1)'(({1'b0, prod_noise} + (PN_W+EST_W+1)'(128))
                   >> FRAC_W);
      end
      S_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  // filter state, written once the result is taken into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        est_r[i] <= '0;
        err_r[i] <= ERR_RESET;
      end
    end else if (out_load && ok_r) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (idx_r == AX_IDX_W'(i)) begin
          est_r[i] <= est_new;
          err_r[i] <= err_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_est_r  <= ok_r ? est_new : '0;
      out_axis_r <= axis_r;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL2) |-> (mag_r <= absdiff_r))
    else $error("estimate step larger than the difference");
  a_write_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) && ok_r |-> ({1'b0, idx_r} < (AX_IDX_W+1)'(NUM_AXES)))
    else $error("state update for an axis that does not exist");
`endif

endmodule
`default_nettype wire

### design/three_axis_scalar_kalman.sv
// top level: configuration registers, front queue and update engine
`default_nettype none
// Scalar Kalman smoother for three accelerometer axes. Each request carries a
// signed 16-bit sample and an axis number; the block keeps an estimate
// (signed Q16.8) and an error (unsigned Q8.16) per axis and returns exactly
// one result per request: the new estimate and the axis. Axis 3 changes
// nothing and returns an estimate of 0. A request for a real axis goes in
// the update engine through the 16-step restoring divider that forms the
// gain, then three multiply states and a write; with measure_error at zero
// the divider is skipped, and an ignored axis goes straight to the write.
// A two-entry queue takes requests while the engine works, and the result
// register holds a finished result while the engine starts on the next
// request. Registers: measure_error at 0x0 (Q8.16, reset 1.0) and
// process_noise at 0x4 (Q0.16, reset 655); write them only while the block
// is idle.
module three_axis_scalar_kalman (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [sk3_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic [sk3_pkg::AXIS_W-1:0]           in_axis,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [sk3_pkg::EST_W-1:0]          out_estimate,
  output logic [sk3_pkg::AXIS_W-1:0]                out_axis_out,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sk3_pkg::APB_AW-1:0]           paddr,
  input  wire logic [sk3_pkg::APB_DW-1:0]           pwdata,
  output logic [sk3_pkg::APB_DW-1:0]                prdata,
  output logic                                      pready
);
  import sk3_pkg::*;

  logic [ME_W-1:0] measure_error_r;
  logic [PN_W-1:0] process_noise_r;
  logic            cfg_wr;
  logic            reg_sel;
  logic            q_valid;
  logic            q_pop;
  sk3_req_t        q_req;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measure_error_r <= ME_RESET;
      process_noise_r <= PN_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MEASURE_ERROR: measure_error_r <= pwdata[ME_W-1:0];
        REG_PROCESS_NOISE: process_noise_r <= pwdata[PN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MEASURE_ERROR: prdata = {{(APB_DW-ME_W){1'b0}}, measure_error_r};
      REG_PROCESS_NOISE: prdata = {{(APB_DW-PN_W){1'b0}}, process_noise_r};
      default:           prdata = '0;
    endcase
  end

  sk3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .in_axis   (in_axis),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop)
  );

  sk3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .measure_error (measure_error_r),
    .process_noise (process_noise_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_estimate  (out_estimate),
    .out_axis      (out_axis_out)
  );

endmodule
`default_nettype wire

### bench/three_axis_scalar_kalman_tb.sv
// self-checking testbench for the three-axis scalar kalman block with a bit-exact predictor
`timescale 1ns / 100ps
module three_axis_scalar_kalman_tb;
  import sk3_pkg::*;

  localparam int PHASES          = 8;
  localparam int PHASE_SAMPLES   = 226;
  localparam int PRESSURE_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 30;
  localparam int REPORT_LIMIT    = 40;
  localparam int LIMIT_NS        = 16_000_000;

  typedef struct {
    logic signed [EST_W-1:0] estimate;
    logic [AXIS_W-1:0]       axis;
  } axis_estimate_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [AXIS_W-1:0]          in_axis;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [EST_W-1:0]    out_estimate;
  logic [AXIS_W-1:0]          out_axis_out;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_AW-1:0]          paddr;
  logic [APB_DW-1:0]          pwdata;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  // predictor state, one estimate and one error per axis
  logic signed [EST_W-1:0] model_est [NUM_AXES];
  logic [ERR_W-1:0]        model_err [NUM_AXES];
  logic [ME_W-1:0]         model_me;
  logic [PN_W-1:0]         model_pn;

  axis_estimate_t pending_estimates [$];

  int  mismatches;
  int  samples_sent;
  int  estimates_checked;
  int  reg_writes;
  int  hold_requests;
  bit  gaps_on;

  three_axis_scalar_kalman dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_axis      (in_axis),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_estimate (out_estimate),
    .out_axis_out (out_axis_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly back to back, sometimes a few cycles, now and then a long pause
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (!gaps_on || r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // one kalman update of the addressed axis, returns the estimate it produces
  function automatic axis_estimate_t track_axis(logic signed [SAMPLE_W-1:0] smp,
                                                logic [AXIS_W-1:0] ax);
    axis_estimate_t     r;
    logic [63:0]        den, quo, prod, keep, noise, sum;
    logic [GAIN_W-1:0]  gain;
    logic signed [31:0] last, tgt, diff, nxt;
    logic [31:0]        absd, mag;
    r.axis = ax;
    r.estimate = '0;
    if (ax >= NUM_AXES) return r;
    last = model_est[ax];
    den = 64'(model_err[ax]) + 64'(model_me);
    if (den == 64'd0) begin
      gain = '0;
    end else begin
      quo = (64'(model_err[ax]) << 16) / den;
      gain = (quo > 64'(GAIN_MAX)) ? GAIN_MAX : quo[GAIN_W-1:0];
    end
    tgt = smp;
    tgt = tgt * 256;
    diff = tgt - last;
    absd = (diff < 0) ? -diff : diff;
    prod = (64'(gain) * 64'(absd) + 64'd32768) >> 16;
    mag = prod[31:0];
    nxt = (diff < 0) ? last - $signed(mag) : last + $signed(mag);
    keep = (64'(ONE_Q16) - 64'(gain)) * 64'(model_err[ax]);
    keep = (keep + 64'd32768) >> 16;
    noise = (64'(mag) * 64'(model_pn) + 64'd128) >> 8;
    sum = keep + noise;
    if (sum > 64'(ERR_MAX)) sum = 64'(ERR_MAX);
    model_est[ax] = nxt[EST_W-1:0];
    model_err[ax] = sum[ERR_W-1:0];
    r.estimate = nxt[EST_W-1:0];
    return r;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                             input logic [AXIS_W-1:0] ax);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    in_axis   <= ax;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_estimates.push_back(track_axis(smp, ax));
    samples_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MEASURE_ERROR) model_me = val[ME_W-1:0];
    else model_pn = val[PN_W-1:0];
    reg_writes++;
  endtask

  // let every outstanding request come back before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extremes of the sample on axes 0 and 2, zero on axis 1, and the ignored axis
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 2'd0);
    send_sample(-16'sh8000, 2'd0);
    send_sample(16'sh0000, 2'd1);
    send_sample(16'sh7FFF, 2'd2);
    send_sample(-16'sh0001, 2'd3);
    send_sample(-16'sh8000, 2'd2);
    drain();
  endtask

  // zero measurement error: saturated gain, then error collapses to zero denominator
  task automatic test_gain_limits();
    write_reg(REG_MEASURE_ERROR, 32'd0);
    write_reg(REG_PROCESS_NOISE, 32'd0);
    send_sample(16'sd1000, 2'd1);
    send_sample(-16'sd1000, 2'd1);
    send_sample(16'sh7FFF, 2'd1);
    send_sample(16'sd5, 2'd1);
    drain();
  endtask

  // full swings with heavy process noise drive the error into saturation
  task automatic test_error_saturation();
    write_reg(REG_MEASURE_ERROR, 32'd1);
    write_reg(REG_PROCESS_NOISE, 32'h0000_FFFF);
    send_sample(16'sh7FFF, 2'd0);
    send_sample(-16'sh8000, 2'd0);
    send_sample(16'sh7FFF, 2'd0);
    send_sample(-16'sh8000, 2'd0);
    drain();
    write_reg(REG_MEASURE_ERROR, 32'h00FF_FFFF);
    send_sample(16'sh0000, 2'd0);
    send_sample(16'sh7FFF, 2'd0);
    send_sample(-16'sh8000, 2'd2);
    drain();
  endtask

  // result side holds off while requests keep coming, so the input stalls
  task automatic test_back_pressure();
    int i;
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 24; i++) begin
      send_sample(SAMPLE_W'($urandom()), AXIS_W'(i % NUM_AXES));
    end
    drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int                         phase, n, s, idx;
    int                         lvl [NUM_AXES];
    int unsigned                pick;
    logic [APB_DW-1:0]          me_val, pn_val;
    logic [AXIS_W-1:0]          ax;
    logic signed [SAMPLE_W-1:0] smp;
    foreach (lvl[k]) lvl[k] = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      pn_val = $urandom_range(32'h0000_FFFF);
      case (phase)
        0: begin
          me_val = 32'(ME_RESET);
          pn_val = 32'(PN_RESET);
        end
        1: begin
          me_val = 32'd1;
          pn_val = 32'd0;
        end
        2: begin
          me_val = 32'h00FF_FFFF;
          pn_val = 32'h0000_FFFF;
        end
        3: me_val = 32'd0;
        4: me_val = $urandom_range(32'h00FF_FFFF);
        default: me_val = $urandom_range(32'h0004_0000, 1);
      endcase
      write_reg(REG_MEASURE_ERROR, me_val);
      write_reg(REG_PROCESS_NOISE, pn_val);
      gaps_on = (phase % 3) != 2;
      for (n = 0; n < PHASE_SAMPLES; n++) begin
        pick = $urandom_range(99);
        if (pick < 6) ax = AXIS_W'($urandom_range(2**AXIS_W - 1, NUM_AXES));
        else ax = AXIS_W'($urandom_range(NUM_AXES - 1));
        pick = $urandom_range(99);
        if (pick < 70) begin
          // slowly drifting sensor level with a little noise
          idx = (ax < NUM_AXES) ? int'(ax) : 0;
          lvl[idx] += int'($urandom_range(400)) - 200;
          if (lvl[idx] > 30000) lvl[idx] = 30000;
          if (lvl[idx] < -30000) lvl[idx] = -30000;
          s = lvl[idx] + int'($urandom_range(128)) - 64;
          smp = s[SAMPLE_W-1:0];
        end else if (pick < 90) begin
          smp = SAMPLE_W'($urandom());
        end else begin
          case ($urandom_range(3))
            0: smp = -16'sh8000;
            1: smp = 16'sh7FFF;
            2: smp = 16'sh0000;
            default: smp = -16'sh0001;
          endcase
        end
        send_sample(smp, ax);
      end
      drain();
    end
    gaps_on = 1'b1;
  endtask

  // result side: random stalls, and a long hold-off when one is requested
  initial begin : result_side
    int          hold_seen;
    int unsigned len;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        len = idle_len();
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_result
    axis_estimate_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        mismatches++;
        $error("estimate for axis %0d arrived with no request outstanding", out_axis_out);
      end else begin
        want = pending_estimates.pop_front();
        estimates_checked++;
        // reports are capped so a broken build cannot flood the log
        if (out_estimate !== want.estimate) begin
          if (mismatches < REPORT_LIMIT)
            $error("estimate: expected %0d, got %0d", want.estimate, out_estimate);
          mismatches++;
        end
        if (out_axis_out !== want.axis) begin
          if (mismatches < REPORT_LIMIT)
            $error("axis_out: expected %0d, got %0d", want.axis, out_axis_out);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #LIMIT_NS;
    $display("FAIL three_axis_scalar_kalman");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    in_axis   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    gaps_on   = 1'b1;
    hold_requests = 0;
    mismatches = 0;
    samples_sent = 0;
    estimates_checked = 0;
    reg_writes = 0;
    model_me = ME_RESET;
    model_pn = PN_RESET;
    for (int a = 0; a < NUM_AXES; a++) begin
      model_est[a] = '0;
      model_err[a] = ERR_RESET;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_gain_limits();
    test_error_saturation();
    test_back_pressure();
    test_random_traffic();

    if (pending_estimates.size() != 0) begin
      mismatches++;
      $error("%0d estimates never arrived", pending_estimates.size());
    end
    $display("run covered %0d samples over all axes and %0d register writes",
             samples_sent, reg_writes);
    $display("%0d estimates compared, %0d mismatches", estimates_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS three_axis_scalar_kalman");
    end else begin
      $display("FAIL three_axis_scalar_kalman");
    end
    $finish;
  end

endmodule
